### hw/rtl/aimd_window_control_unit_assert.svh
// Assertion macros for the AIMD window control unit
`ifndef AIMD_WINDOW_CONTROL_UNIT_ASSERT_SVH
`define AIMD_WINDOW_CONTROL_UNIT_ASSERT_SVH

// same-cycle implication
`define AIMD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aimd: same-cycle check failed");

// next-cycle implication
`define AIMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aimd: next-cycle check failed");

`endif

### hw/rtl/aimd_pkg.sv
// Package: types and constants of the AIMD window control unit
`timescale 1ns / 1ps

package aimd_pkg;

  localparam int REC_FRAC = 12;

  localparam logic [1:0] REQ_SENT    = 2'd0;
  localparam logic [1:0] REQ_DATA    = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  localparam logic [2:0] CFG_INITIAL_WINDOW    = 3'd0;
  localparam logic [2:0] CFG_DECREASE_FACTOR   = 3'd1;
  localparam logic [2:0] CFG_SUPPRESS_FACTOR   = 3'd2;
  localparam logic [2:0] CFG_CONSERVATIVE_MODE = 3'd3;
  localparam logic [2:0] CFG_HONOUR_MARKS      = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_GATE,
    ST_RP,
    ST_WIN,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### hw/rtl/aimd_mul.sv
// Registered 32x16 unsigned multiplier shared by the reproduction-point and decrease paths
`timescale 1ns / 1ps

module aimd_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [15:0] b,
  output logic [47:0] p
);

  always_ff @(posedge clk) begin
    p <= {16'd0, a} * {32'd0, b};
  end

endmodule

### hw/rtl/aimd_recip_div.sv
// Serial restoring divider: 2^(2*FRAC_BITS) / divisor, one quotient bit per cycle
`timescale 1ns / 1ps

module aimd_recip_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [31:0]                divisor,
  output logic [2*FRAC_BITS:0]       quotient,
  output aimd_pkg::div_status_t      status
);

  import aimd_pkg::*;

  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int CW = $clog2(QW);

  logic [CW-1:0] cnt;
  logic [31:0]   rem;
  logic          busy;
  logic          done;
  logic          shift_in;
  logic [33:0]   trial;
  logic          fits;

  assign shift_in = (cnt == CW'(QW - 1));
  assign trial    = {1'b0, rem, shift_in} - {2'b00, divisor};
  assign fits     = !trial[33];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt      <= CW'(QW - 1);
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      cnt      <= cnt - 1'b1;
      rem      <= fits ? trial[31:0] : {rem[30:0], shift_in};
      quotient <= {quotient[QW-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

### hw/rtl/aimd_window_control_unit.sv
// Top level: AIMD congestion window controller with conservative adaptation
//
//  channel   | dir | handshake                  | payload
//  s_axis    | in  | s_axis_tvalid/tready       | tdata seq_number, tuser req_type, mark
//  m_axis    | out | m_axis_tvalid/tready       | tdata window, outstanding, status bits
//  cfg       | in  | cfg_en                     | cfg_index, cfg_data
//
// One event per transaction; one result per event. Send, unused kind, ignored
// mark and increase below threshold go from execute straight to done; a decrease
// passes the gate, reproduction-point and window states; a suppressed one stops
// at the gate; an increase above threshold waits on the serial reciprocal divider.
// s_axis_tready is high only when idle; a finished event waits in the sequencer
// until the output register is free. Synchronous reset; no clearing pass.
`timescale 1ns / 1ps
`include "aimd_window_control_unit_assert.svh"

module aimd_window_control_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] seq_number
  input  logic [2:0]  s_axis_tuser,   // [1:0] req_type, [2] congestion_mark
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [31:0] window_size, [47:32] outstanding,
                                      // [48] send_now, [49] send_later,
                                      // [50] decreased, [55:51] zero
  input  logic        cfg_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import aimd_pkg::*;

  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int SW = ((QW > 32) ? QW : 32) + 1;

  state_t state, state_next;

  logic [1:0]  kind;
  logic [31:0] seq;
  logic        mark;
  logic        dec;

  logic [15:0] init_win;
  logic [15:0] dec_fac;
  logic [15:0] sup_fac;
  logic        cons;
  logic        honour;

  logic [31:0] window;
  logic [31:0] ssthresh;
  logic [31:0] ha;
  logic [31:0] nseq;
  logic [47:0] rp;
  logic [15:0] inflight;

  logic [55:0] out_data;
  logic        out_free;
  logic        accept;
  logic        load_out;
  logic        div_start;

  logic [47:0] init_sh;
  logic [31:0] init_q;
  logic [47:0] cfg_sh;
  logic [31:0] cfg_q;
  logic [31:0] diff;
  logic        gate_pass;
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] mul_p;
  logic [48:0] rp_sum;
  logic [31:0] ss_new;
  logic [32:0] add_one;
  logic [32:0] seq_inc;
  logic [SW-1:0] grow_sum;
  logic [47:0] inflight_sh;
  logic        send_now;
  logic        send_later;

  logic [QW-1:0] div_q;
  div_status_t   div_st;

  assign init_sh = {32'd0, init_win} << FRAC_BITS;
  assign init_q  = (|init_sh[47:32]) ? 32'hFFFF_FFFF : init_sh[31:0];
  assign cfg_sh  = {32'd0, cfg_data} << FRAC_BITS;
  assign cfg_q   = (|cfg_sh[47:32]) ? 32'hFFFF_FFFF : cfg_sh[31:0];

  assign diff      = (nseq > ha) ? (nseq - ha) : 32'd0;
  assign gate_pass = !cons || ({4'd0, ha, 12'd0} > rp);
  assign mul_a     = (state == ST_GATE) ? diff : window;
  assign mul_b     = (state == ST_GATE) ? sup_fac : dec_fac;
  assign rp_sum    = {5'd0, nseq, 12'd0} + {1'b0, mul_p};
  assign ss_new    = mul_p[47:16];
  assign add_one   = {1'b0, window} + (33'd1 << FRAC_BITS);
  assign seq_inc   = {1'b0, seq} + 33'd1;
  assign grow_sum  = SW'(window) + SW'(div_q);

  assign inflight_sh = {32'd0, inflight} << FRAC_BITS;
  assign send_now    = (window != 32'd0) && (inflight_sh < {16'd0, window});
  assign send_later  = (window == 32'd0);

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  aimd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  aimd_recip_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (window),
    .quotient (div_q),
    .status   (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (kind)
          REQ_SENT: state_next = ST_DONE;
          REQ_DATA: begin
            if (mark) begin
              state_next = honour ? ST_GATE : ST_DONE;
            end else if (window < ssthresh || window == 32'd0) begin
              state_next = ST_DONE;
            end else begin
              state_next = ST_DIV;
              div_start  = 1'b1;
            end
          end
          REQ_TIMEOUT: state_next = ST_GATE;
          default: state_next = ST_DONE;
        endcase
      end
      ST_GATE: begin
        state_next = gate_pass ? ST_RP : ST_DONE;
      end
      ST_RP: state_next = ST_WIN;
      ST_WIN: state_next = ST_DONE;
      ST_DIV: begin
        if (div_st.done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= s_axis_tuser[1:0];
      mark <= s_axis_tuser[2];
      seq  <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_win <= 16'd1;
      dec_fac  <= 16'd32768;
      sup_fac  <= 16'd2048;
      cons     <= 1'b1;
      honour   <= 1'b1;
    end else if (cfg_en) begin
      case (cfg_index)
        CFG_INITIAL_WINDOW:    init_win <= cfg_data;
        CFG_DECREASE_FACTOR:   dec_fac  <= cfg_data;
        CFG_SUPPRESS_FACTOR:   sup_fac  <= cfg_data;
        CFG_CONSERVATIVE_MODE: cons     <= cfg_data[0];
        CFG_HONOUR_MARKS:      honour   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= 32'd1 << FRAC_BITS;
      ssthresh <= 32'hFFFF_FFFF;
      ha       <= '0;
      nseq     <= '0;
      rp       <= '0;
      inflight <= '0;
      dec      <= 1'b0;
    end else begin
      if (cfg_en && cfg_index == CFG_INITIAL_WINDOW) window <= cfg_q;
      if (accept) dec <= 1'b0;
      case (state)
        ST_EXEC: begin
          case (kind)
            REQ_SENT: begin
              if (inflight != 16'hFFFF) inflight <= inflight + 1'b1;
              if (seq_inc[32]) begin
                nseq <= 32'hFFFF_FFFF;
              end else if (seq_inc[31:0] > nseq) begin
                nseq <= seq_inc[31:0];
              end
            end
            REQ_DATA: begin
              if (seq > ha) ha <= seq;
              if (inflight != 16'd0) inflight <= inflight - 1'b1;
              if (!mark) begin
                if (window < ssthresh) begin
                  window <= add_one[32] ? 32'hFFFF_FFFF : add_one[31:0];
                end else if (window == 32'd0) begin
                  window <= 32'hFFFF_FFFF;
                end
              end
            end
            REQ_TIMEOUT: begin
              if (inflight != 16'd0) inflight <= inflight - 1'b1;
            end
            default: ;
          endcase
        end
        ST_RP: begin
          rp <= rp_sum[48] ? 48'hFFFF_FFFF_FFFF : rp_sum[47:0];
        end
        ST_WIN: begin
          ssthresh <= ss_new;
          window   <= (ss_new < init_q) ? init_q : ss_new;
          dec      <= 1'b1;
        end
        ST_DIV: begin
          if (div_st.done) begin
            window <= (|grow_sum[SW-1:32]) ? 32'hFFFF_FFFF : grow_sum[31:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {5'd0, dec, send_later, send_now, inflight, window};
    end
  end

  assign m_axis_tdata = out_data;

  `AIMD_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready)
  `AIMD_ASSERT_NOW(a_div_only_in_div, div_st.busy, state == ST_DIV)
  `AIMD_ASSERT_NOW(a_status_exclusive, m_axis_tvalid, !(m_axis_tdata[48] && m_axis_tdata[49]))
  `AIMD_ASSERT_NEXT(a_load_shows_result, load_out, m_axis_tvalid && s_axis_tready)

endmodule
